// ----- rtl/sgq_pkg.sv -----
// Shared types, constants and gain tables for the spectral gain quantizer.
`default_nettype none

package sgq_pkg;

   localparam int COEF_WIDTH  = 32;
   localparam int QUANT_WIDTH = 16;
   localparam int COUNT_WIDTH = 10;
   localparam int INDEX_WIDTH = 9;
   localparam int MANT_WIDTH  = 24;
   localparam int SHIFT_WIDTH = 8;
   localparam int PROD_WIDTH  = COEF_WIDTH + MANT_WIDTH;

   localparam logic [MANT_WIDTH-1:0]  MANT_ONE    = 24'h800000;
   localparam logic [INDEX_WIDTH-1:0] INDEX_MIN   = 9'h100;
   localparam logic [24:0]            QUANT_MAX   = 25'd32767;
   localparam logic [32:0]            QUANT_ROUND = 33'd96;
   localparam logic [31:0]            LIMIT_POS   = 32'h7fff_ffff;
   localparam logic [31:0]            LIMIT_NEG   = 32'h8000_0000;
   localparam logic [5:0]             DIV_STEPS   = 6'd47;

   typedef enum logic [2:0] {
      GAIN_IDLE,
      GAIN_MUL,
      GAIN_NORM,
      GAIN_RECIP,
      GAIN_DIV,
      GAIN_FIX
   } gain_state_type;

   typedef struct packed {
      logic [MANT_WIDTH-1:0]  mantissa;
      logic [SHIFT_WIDTH-1:0] shift;
   } gain_type;

   typedef struct packed {
      logic adv_a;
      logic adv_b;
      logic adv_c;
      logic adv_d;
   } lane_ctrl_type;

   function automatic logic [MANT_WIDTH-1:0] pow_mant(input logic [2:0] k);
      logic [MANT_WIDTH-1:0] m;
      case (k)
         3'd0:    m = 24'd9107605;
         3'd1:    m = 24'd9888228;
         3'd2:    m = 24'd11655933;
         3'd3:    m = 24'd16195866;
         3'd4:    m = 24'd15634661;
         3'd5:    m = 24'd14569916;
         3'd6:    m = 24'd12653021;
         default: m = 24'd9542640;
      endcase
      return m;
   endfunction

   function automatic logic [SHIFT_WIDTH-1:0] pow_exp(input logic [2:0] k);
      logic [SHIFT_WIDTH-1:0] e;
      case (k)
         3'd4:    e = 8'd1;
         3'd5:    e = 8'd3;
         3'd6:    e = 8'd7;
         3'd7:    e = 8'd15;
         default: e = 8'd0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sgq_gain.sv -----
// Forms the inverse gain mantissa and shift from the gain index with one multiplier and a serial divider.
`default_nettype none

module sgq_gain (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [sgq_pkg::INDEX_WIDTH-1:0]  csr_gain_index,
   output sgq_pkg::gain_type                     gain,
   output logic                                  busy
);

   sgq_pkg::gain_state_type state_ff, state_in;
   logic [sgq_pkg::MANT_WIDTH-1:0]  mant_out_ff, mant_out_in;
   logic [sgq_pkg::SHIFT_WIDTH-1:0] shift_out_ff, shift_out_in;
   logic [7:0]                      abs_ff, abs_in;
   logic                            positive_ff, positive_in;
   logic [2:0]                      k_ff, k_in;
   logic [sgq_pkg::MANT_WIDTH-1:0]  m_ff, m_in;
   logic [sgq_pkg::SHIFT_WIDTH-1:0] e_ff, e_in;
   logic [47:0]                     prod_ff, prod_in;
   logic [47:0]                     num_ff, num_in;
   logic [23:0]                     rem_ff, rem_in;
   logic [24:0]                     quo_ff, quo_in;
   logic [5:0]                      cnt_ff, cnt_in;

   always_comb begin
      logic [8:0]  neg_idx;
      logic [48:0] rnd;
      logic [24:0] m25;
      logic        inc1;
      logic        inc2;
      logic [24:0] rem_next;
      logic        qbit;

      state_in     = state_ff;
      mant_out_in  = mant_out_ff;
      shift_out_in = shift_out_ff;
      abs_in       = abs_ff;
      positive_in  = positive_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;

      neg_idx  = 9'(-csr_gain_index);
      inc1     = prod_ff[47];
      rnd      = inc1 ? ({1'b0, prod_ff} + 49'h0_0080_0000) >> 24
                      : ({1'b0, prod_ff} + 49'h0_0040_0000) >> 23;
      m25      = rnd[24:0];
      inc2     = m25[24];
      rem_next = {rem_ff, num_ff[47]};
      qbit     = rem_next >= {1'b0, m_ff};

      unique case (state_ff)
         sgq_pkg::GAIN_IDLE: begin
            if (csr_write_enable) begin
               if (csr_gain_index == sgq_pkg::INDEX_MIN) begin
                  abs_in = 8'd255;
               end else if (csr_gain_index[8]) begin
                  abs_in = neg_idx[7:0];
               end else begin
                  abs_in = csr_gain_index[7:0];
               end
               positive_in = !csr_gain_index[8] && (csr_gain_index != '0);
               m_in        = sgq_pkg::MANT_ONE;
               e_in        = '0;
               k_in        = '0;
               state_in    = sgq_pkg::GAIN_MUL;
            end
         end
         sgq_pkg::GAIN_MUL: begin
            prod_in  = m_ff * sgq_pkg::pow_mant(k_ff);
            state_in = sgq_pkg::GAIN_NORM;
         end
         sgq_pkg::GAIN_NORM: begin
            if (abs_ff[k_ff]) begin
               m_in = inc2 ? m25[24:1] : m25[23:0];
               e_in = e_ff + sgq_pkg::pow_exp(k_ff) + 8'(inc1) + 8'(inc2);
            end
            if (k_ff == 3'd7) begin
               state_in = sgq_pkg::GAIN_RECIP;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = sgq_pkg::GAIN_MUL;
            end
         end
         sgq_pkg::GAIN_RECIP: begin
            if (!positive_ff) begin
               mant_out_in  = m_ff;
               shift_out_in = e_ff;
               state_in     = sgq_pkg::GAIN_IDLE;
            end else if (m_ff == sgq_pkg::MANT_ONE) begin
               mant_out_in  = m_ff;
               shift_out_in = 8'(-e_ff);
               state_in     = sgq_pkg::GAIN_IDLE;
            end else begin
               e_in     = 8'(-e_ff) - 8'd1;
               num_in   = 48'h8000_0000_0000 + {25'd0, m_ff[23:1]};
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = sgq_pkg::DIV_STEPS;
               state_in = sgq_pkg::GAIN_DIV;
            end
         end
         sgq_pkg::GAIN_DIV: begin
            rem_in = qbit ? 24'(rem_next - {1'b0, m_ff}) : rem_next[23:0];
            quo_in = {quo_ff[23:0], qbit};
            num_in = {num_ff[46:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = sgq_pkg::GAIN_FIX;
            end
         end
         sgq_pkg::GAIN_FIX: begin
            if (quo_ff[24]) begin
               mant_out_in  = quo_ff[24:1];
               shift_out_in = e_ff + 8'd1;
            end else begin
               mant_out_in  = quo_ff[23:0];
               shift_out_in = e_ff;
            end
            state_in = sgq_pkg::GAIN_IDLE;
         end
         default: begin
            state_in = sgq_pkg::GAIN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sgq_pkg::GAIN_IDLE;
         mant_out_ff  <= sgq_pkg::MANT_ONE;
         shift_out_ff <= '0;
      end else begin
         state_ff     <= state_in;
         mant_out_ff  <= mant_out_in;
         shift_out_ff <= shift_out_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_ff      <= abs_in;
      positive_ff <= positive_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      e_ff        <= e_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
   end

   assign gain.mantissa = mant_out_ff;
   assign gain.shift    = shift_out_ff;
   assign busy          = state_ff != sgq_pkg::GAIN_IDLE;

endmodule

`default_nettype wire

// ----- rtl/sgq_lane.sv -----
// One coefficient lane: multiply by the gain, shift with rounding and saturation, then quantize.
`default_nettype none

module sgq_lane (
   input  wire logic                              clock,
   input  wire sgq_pkg::lane_ctrl_type            ctrl,
   input  wire sgq_pkg::gain_type                 gain,
   input  wire logic [sgq_pkg::COEF_WIDTH-1:0]    coef,
   output logic [sgq_pkg::QUANT_WIDTH-1:0]        quant,
   output logic [sgq_pkg::COEF_WIDTH-1:0]         scaled,
   output logic                                   nonzero
);

   logic [sgq_pkg::COEF_WIDTH-1:0]  coef_ff;
   logic [sgq_pkg::PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic                            neg_b_ff;
   logic [31:0]                     mag_ff, mag_in;
   logic                            neg_c_ff;
   logic [sgq_pkg::QUANT_WIDTH-1:0] quant_ff, quant_in;
   logic [sgq_pkg::COEF_WIDTH-1:0]  scaled_ff, scaled_in;
   logic [24:0]                     q_raw;

   always_comb begin
      logic [31:0] mag;
      mag     = coef_ff[31] ? 32'(-coef_ff) : coef_ff;
      prod_in = mag * gain.mantissa;
   end

   always_comb begin
      logic signed [9:0] s;
      logic [9:0]        t;
      logic [5:0]        t6;
      logic [63:0]       r;
      logic [56:0]       rnd;
      logic [31:0]       limit;

      limit = neg_b_ff ? sgq_pkg::LIMIT_NEG : sgq_pkg::LIMIT_POS;
      s     = $signed({{2{gain.shift[7]}}, gain.shift}) - 10'sd23;
      t     = 10'(-s);
      t6    = t[5:0];
      rnd   = {1'b0, prod_ff} + (57'd1 << (t6 - 6'd1));
      if (s > 10'sd8) begin
         r = (prod_ff != '0) ? {32'd0, limit} : 64'd0;
      end else if (s >= 10'sd0) begin
         r = {8'd0, prod_ff} << s[3:0];
      end else if (t >= 10'd57) begin
         r = 64'd0;
      end else begin
         r = {7'd0, rnd >> t6};
      end
      mag_in = (r > {32'd0, limit}) ? limit : r[31:0];
   end

   always_comb begin
      logic [32:0] biased;
      biased    = {1'b0, mag_ff} + sgq_pkg::QUANT_ROUND;
      q_raw     = biased[32:8];
      quant_in  = (q_raw > sgq_pkg::QUANT_MAX) ? sgq_pkg::QUANT_MAX[15:0] : q_raw[15:0];
      if (neg_c_ff) begin
         quant_in  = 16'(-quant_in);
         scaled_in = 32'(-mag_ff);
      end else begin
         scaled_in = mag_ff;
      end
      nonzero = q_raw != '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_a) begin
         coef_ff <= coef;
      end
      if (ctrl.adv_b) begin
         prod_ff  <= prod_in;
         neg_b_ff <= coef_ff[31];
      end
      if (ctrl.adv_c) begin
         mag_ff   <= mag_in;
         neg_c_ff <= neg_b_ff;
      end
      if (ctrl.adv_d) begin
         quant_ff  <= quant_in;
         scaled_ff <= scaled_in;
      end
   end

   assign quant  = quant_ff;
   assign scaled = scaled_ff;

endmodule

`default_nettype wire

// ----- rtl/sgq_merge.sv -----
// Merges the lane results into the frame position, significant count and frame end flag.
`default_nettype none

module sgq_merge #(
   parameter int MAX_COEFS = 512
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sgq_pkg::lane_ctrl_type            ctrl,
   input  wire logic                              last_pair,
   input  wire logic                              nonzero_a,
   input  wire logic                              nonzero_b,
   output logic [sgq_pkg::COUNT_WIDTH-1:0]        significant_count,
   output logic                                   frame_done
);

   localparam logic [sgq_pkg::COUNT_WIDTH:0] PAIR_LIMIT =
      (sgq_pkg::COUNT_WIDTH + 1)'(MAX_COEFS / 2);

   logic [sgq_pkg::COUNT_WIDTH-1:0] position_ff, position_in;
   logic [sgq_pkg::COUNT_WIDTH-1:0] sig_end_ff, sig_end_in;
   logic [sgq_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                            done_ff, done_in;

   always_comb begin
      logic [sgq_pkg::COUNT_WIDTH:0] next_pos;
      logic [sgq_pkg::COUNT_WIDTH:0] doubled;
      logic [sgq_pkg::COUNT_WIDTH-1:0] sig;

      position_in = position_ff;
      sig_end_in  = sig_end_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      next_pos    = {1'b0, position_ff} + 1'b1;
      doubled     = next_pos << 1;
      sig         = (nonzero_a || nonzero_b) ? doubled[sgq_pkg::COUNT_WIDTH-1:0] : sig_end_ff;
      if (ctrl.adv_d) begin
         count_in = sig;
         done_in  = last_pair || (next_pos >= PAIR_LIMIT);
         if (done_in) begin
            position_in = '0;
            sig_end_in  = '0;
         end else begin
            position_in = next_pos[sgq_pkg::COUNT_WIDTH-1:0];
            sig_end_in  = sig;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         sig_end_ff  <= '0;
      end else begin
         position_ff <= position_in;
         sig_end_ff  <= sig_end_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      done_ff  <= done_in;
   end

   assign significant_count = count_ff;
   assign frame_done        = done_ff;

endmodule

`default_nettype wire

// ----- rtl/spectral_gain_quantizer.sv -----
// Top level of the spectral gain quantizer: two coefficient lanes, gain former and merge stage.
// Stages a, b, c and d each register the transaction in turn; one transaction is taken per cycle
// unless req_ready is low. Each stage holds its transaction until the next stage has room, so
// bubbles fill under stalls. A gain index write holds req_ready low while the shared multiplier
// and, for a positive index, the bit-serial divider form the gain.
// Synchronous reset empties the pipeline, clears the frame counters and sets the gain to unity.
`default_nettype none

module spectral_gain_quantizer #(
   parameter int MAX_COEFS = 512
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sgq_pkg::COEF_WIDTH-1:0]    req_coef_a,
   input  wire logic [sgq_pkg::COEF_WIDTH-1:0]    req_coef_b,
   input  wire logic                              req_last_pair,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [sgq_pkg::QUANT_WIDTH-1:0]        rsp_quant_a,
   output logic [sgq_pkg::QUANT_WIDTH-1:0]        rsp_quant_b,
   output logic [sgq_pkg::COEF_WIDTH-1:0]         rsp_scaled_a,
   output logic [sgq_pkg::COEF_WIDTH-1:0]         rsp_scaled_b,
   output logic [sgq_pkg::COUNT_WIDTH-1:0]        rsp_significant_count,
   output logic                                   rsp_frame_done,
   input  wire logic                              csr_write_enable,
   input  wire logic [sgq_pkg::INDEX_WIDTH-1:0]   csr_gain_index
);

   sgq_pkg::gain_type      gain;
   sgq_pkg::lane_ctrl_type ctrl;
   logic busy;
   logic valid_a_ff, valid_a_in;
   logic valid_b_ff, valid_b_in;
   logic valid_c_ff, valid_c_in;
   logic valid_d_ff, valid_d_in;
   logic last_a_ff, last_b_ff, last_c_ff;
   logic ready_a, ready_b, ready_c, ready_d;
   logic nonzero_a, nonzero_b;

   assign ready_d    = !valid_d_ff || rsp_ready;
   assign ready_c    = !valid_c_ff || ready_d;
   assign ready_b    = !valid_b_ff || ready_c;
   assign ready_a    = !valid_a_ff || ready_b;
   assign req_ready  = ready_a && !busy && !csr_write_enable;

   assign ctrl.adv_a = req_valid && req_ready;
   assign ctrl.adv_b = valid_a_ff && ready_b;
   assign ctrl.adv_c = valid_b_ff && ready_c;
   assign ctrl.adv_d = valid_c_ff && ready_d;

   assign valid_a_in = ctrl.adv_a || (valid_a_ff && !ctrl.adv_b);
   assign valid_b_in = ctrl.adv_b || (valid_b_ff && !ctrl.adv_c);
   assign valid_c_in = ctrl.adv_c || (valid_c_ff && !ctrl.adv_d);
   assign valid_d_in = ctrl.adv_d || (valid_d_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
         valid_d_ff <= valid_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv_a) begin
         last_a_ff <= req_last_pair;
      end
      if (ctrl.adv_b) begin
         last_b_ff <= last_a_ff;
      end
      if (ctrl.adv_c) begin
         last_c_ff <= last_b_ff;
      end
   end

   sgq_gain u_gain (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_gain_index   (csr_gain_index),
      .gain             (gain),
      .busy             (busy)
   );

   sgq_lane u_lane_a (
      .clock   (clock),
      .ctrl    (ctrl),
      .gain    (gain),
      .coef    (req_coef_a),
      .quant   (rsp_quant_a),
      .scaled  (rsp_scaled_a),
      .nonzero (nonzero_a)
   );

   sgq_lane u_lane_b (
      .clock   (clock),
      .ctrl    (ctrl),
      .gain    (gain),
      .coef    (req_coef_b),
      .quant   (rsp_quant_b),
      .scaled  (rsp_scaled_b),
      .nonzero (nonzero_b)
   );

   sgq_merge #(
      .MAX_COEFS (MAX_COEFS)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .last_pair         (last_c_ff),
      .nonzero_a         (nonzero_a),
      .nonzero_b         (nonzero_b),
      .significant_count (rsp_significant_count),
      .frame_done        (rsp_frame_done)
   );

   assign rsp_valid = valid_d_ff;

endmodule

`default_nettype wire

// ----- rtl/sgq_checker.sv -----
// Port-level checks for the spectral gain quantizer and the bind that attaches them.
`default_nettype none

module sgq_port_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [sgq_pkg::QUANT_WIDTH-1:0]   rsp_quant_a,
   input wire logic [sgq_pkg::QUANT_WIDTH-1:0]   rsp_quant_b,
   input wire logic [sgq_pkg::COEF_WIDTH-1:0]    rsp_scaled_a,
   input wire logic [sgq_pkg::COEF_WIDTH-1:0]    rsp_scaled_b,
   input wire logic [sgq_pkg::COUNT_WIDTH-1:0]   rsp_significant_count,
   input wire logic                              rsp_frame_done,
   input wire logic                              csr_write_enable
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quant_a) && $stable(rsp_quant_b)
         && $stable(rsp_scaled_a) && $stable(rsp_scaled_b)
         && $stable(rsp_significant_count) && $stable(rsp_frame_done))
      else $error("result changed while stalled");

   // Gain forming blocks new input transactions right after a register write.
   assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !req_ready)
      else $error("input accepted while the gain is being formed");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A nonzero quantized value in lane a carries the sign of its scaled value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_quant_a != '0) |-> rsp_quant_a[15] == rsp_scaled_a[31])
      else $error("quantized and scaled signs disagree");

endmodule

bind spectral_gain_quantizer sgq_port_checker u_sgq_port_checker (.*);

`default_nettype wire

// ----- tb/sgq_checker.sv -----
// Checker for the spectral gain quantizer: predicts every result and compares it on arrival.
module sgq_checker #(
   parameter int MAX_COEFS = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [31:0] req_coef_a,
   input  wire logic [31:0] req_coef_b,
   input  wire logic        req_last_pair,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_quant_a,
   input  wire logic [15:0] rsp_quant_b,
   input  wire logic [31:0] rsp_scaled_a,
   input  wire logic [31:0] rsp_scaled_b,
   input  wire logic [9:0]  rsp_significant_count,
   input  wire logic        rsp_frame_done,
   input  wire logic        csr_write_enable,
   input  wire logic [8:0]  csr_gain_index,
   output int               mismatch_count,
   output int               pending_count
);

   typedef struct packed {
      logic [15:0] quant;
      logic [31:0] scaled;
      logic        nonzero;
   } lane_result_type;

   typedef struct packed {
      logic [15:0] quant_a;
      logic [15:0] quant_b;
      logic [31:0] scaled_a;
      logic [31:0] scaled_b;
      logic [9:0]  count;
      logic        done;
   } quant_result_type;

   quant_result_type   expected_results[$];
   sgq_pkg::gain_type  inv_gain;
   int                 pair_pos = 0;
   int                 sig_end = 0;
   int                 errors = 0;

   function automatic longint unsigned to_q23(input longint unsigned decimal, input int sh);
      return ((decimal << sh) + 64'd50000000) / 64'd100000000;
   endfunction

   function automatic longint unsigned step_mantissa(input int k);
      case (k)
         0:       return to_q23(64'd108571112, 23);
         1:       return to_q23(64'd117876863, 23);
         2:       return to_q23(64'd138949549, 23);
         3:       return to_q23(64'd193069773, 23);
         4:       return to_q23(64'd372759372, 22);
         5:       return to_q23(64'd1389495490, 20);
         6:       return to_q23(64'd19306977300, 16);
         default: return to_q23(64'd3727593720000, 8);
      endcase
   endfunction

   function automatic int step_exponent(input int k);
      case (k)
         4:       return 1;
         5:       return 3;
         6:       return 7;
         7:       return 15;
         default: return 0;
      endcase
   endfunction

   function automatic sgq_pkg::gain_type inverse_gain(input logic [8:0] index);
      int                g;
      int                mag;
      int                e;
      longint unsigned   m;
      longint unsigned   p;
      sgq_pkg::gain_type r;
      g = $signed(index);
      if (g < -255) g = -255;
      mag = (g < 0) ? -g : g;
      m = 64'h800000;
      e = 0;
      for (int k = 0; k < 8; k++) begin
         if (mag[k]) begin
            p = m * step_mantissa(k);
            e += step_exponent(k);
            if (p >= (64'd1 << 47)) begin
               m = (p + (64'd1 << 23)) >> 24;
               e += 1;
            end else begin
               m = (p + (64'd1 << 22)) >> 23;
            end
            if (m >= (64'd1 << 24)) begin
               m >>= 1;
               e += 1;
            end
         end
      end
      if (g > 0) begin
         if (m == 64'h800000) begin
            e = -e;
         end else begin
            m = ((64'd1 << 47) + (m >> 1)) / m;
            e = -e - 1;
            if (m >= (64'd1 << 24)) begin
               m >>= 1;
               e += 1;
            end
         end
      end
      r.mantissa = m[23:0];
      r.shift = e[7:0];
      return r;
   endfunction

   function automatic lane_result_type quantize_lane(input logic [31:0] coef,
                                                     input sgq_pkg::gain_type gn);
      logic            neg;
      longint unsigned mag;
      longint unsigned limit;
      longint unsigned p;
      longint unsigned sm;
      longint unsigned q;
      longint unsigned t;
      int              s;
      lane_result_type r;
      neg = coef[31];
      mag = neg ? (64'h1_0000_0000 - coef) : coef;
      limit = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      p = mag * gn.mantissa;
      s = $signed(gn.shift) - 23;
      if (s >= 0) begin
         if (s > 8) sm = (p != 0) ? limit : 0;
         else sm = p << s;
      end else if (-s >= 63) begin
         sm = 0;
      end else begin
         sm = (p + (64'd1 << (-s - 1))) >> (-s);
      end
      if (sm > limit) sm = limit;
      q = (sm + 64'd96) >> 8;
      if (q > 64'd32767) q = 64'd32767;
      t = neg ? (64'h1_0000_0000 - sm) : sm;
      r.scaled = t[31:0];
      t = neg ? (64'h1_0000 - q) : q;
      r.quant = t[15:0];
      r.nonzero = (q != 0);
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         if (errors < 10) $display("Mismatch on %s: expected %h, actual %h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      quant_result_type want;
      lane_result_type  lane_a;
      lane_result_type  lane_b;
      logic             done;
      if (reset) begin
         expected_results.delete();
         inv_gain = inverse_gain(9'd0);
         pair_pos = 0;
         sig_end = 0;
      end else begin
         if (csr_write_enable) inv_gain = inverse_gain(csr_gain_index);
         if (req_valid && req_ready) begin
            lane_a = quantize_lane(req_coef_a, inv_gain);
            lane_b = quantize_lane(req_coef_b, inv_gain);
            if (lane_a.nonzero || lane_b.nonzero) sig_end = (pair_pos + 1) * 2;
            done = req_last_pair || (pair_pos + 1 >= MAX_COEFS / 2);
            want.quant_a = lane_a.quant;
            want.quant_b = lane_b.quant;
            want.scaled_a = lane_a.scaled;
            want.scaled_b = lane_b.scaled;
            want.count = sig_end[9:0];
            want.done = done;
            expected_results.push_back(want);
            if (done) begin
               pair_pos = 0;
               sig_end = 0;
            end else begin
               pair_pos = (pair_pos + 1) % 1024;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (errors < 10) $display("Result transaction with nothing pending, quant_a %h",
                                         rsp_quant_a);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("quant_a", want.quant_a, rsp_quant_a);
               check_field("quant_b", want.quant_b, rsp_quant_b);
               check_field("scaled_a", want.scaled_a, rsp_scaled_a);
               check_field("scaled_b", want.scaled_b, rsp_scaled_b);
               check_field("significant_count", want.count, rsp_significant_count);
               check_field("frame_done", want.done, rsp_frame_done);
            end
         end
      end
      mismatch_count <= errors;
      pending_count <= expected_results.size();
   end

endmodule

// ----- tb/tb_spectral_gain_quantizer.sv -----
// Testbench top for the spectral gain quantizer: stimulus, flow control, watchdog and verdict.
module tb_spectral_gain_quantizer;

   localparam int MAX_COEFS  = 512;
   localparam int IDLE_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_coef_a = '0;
   logic [31:0] req_coef_b = '0;
   logic        req_last_pair = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_quant_a;
   logic [15:0] rsp_quant_b;
   logic [31:0] rsp_scaled_a;
   logic [31:0] rsp_scaled_b;
   logic [9:0]  rsp_significant_count;
   logic        rsp_frame_done;
   logic        csr_write_enable = 1'b0;
   logic [8:0]  csr_gain_index = '0;

   int          mismatch_count;
   int          pending_count;
   int          idle_cycles = 0;
   logic        sender_burst = 1'b0;
   logic        rsp_burst = 1'b0;
   int          rsp_draw;
   int          rsp_wait = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   spectral_gain_quantizer #(
      .MAX_COEFS(MAX_COEFS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_coef_a           (req_coef_a),
      .req_coef_b           (req_coef_b),
      .req_last_pair        (req_last_pair),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_quant_a          (rsp_quant_a),
      .rsp_quant_b          (rsp_quant_b),
      .rsp_scaled_a         (rsp_scaled_a),
      .rsp_scaled_b         (rsp_scaled_b),
      .rsp_significant_count(rsp_significant_count),
      .rsp_frame_done       (rsp_frame_done),
      .csr_write_enable     (csr_write_enable),
      .csr_gain_index       (csr_gain_index)
   );

   sgq_checker #(
      .MAX_COEFS(MAX_COEFS)
   ) i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_coef_a           (req_coef_a),
      .req_coef_b           (req_coef_b),
      .req_last_pair        (req_last_pair),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_quant_a          (rsp_quant_a),
      .rsp_quant_b          (rsp_quant_b),
      .rsp_scaled_a         (rsp_scaled_a),
      .rsp_scaled_b         (rsp_scaled_b),
      .rsp_significant_count(rsp_significant_count),
      .rsp_frame_done       (rsp_frame_done),
      .csr_write_enable     (csr_write_enable),
      .csr_gain_index       (csr_gain_index),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count)
   );

   // The result side holds ready low for a freshly drawn wait after each transaction, unless the draw is zero.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            rsp_draw = rsp_burst ? 0 : $urandom_range(0, 11);
            if (rsp_draw != 0) begin
               rsp_ready <= 1'b0;
               rsp_wait <= rsp_draw;
            end
         end
      end else if (rsp_wait <= 1) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_wait <= rsp_wait - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [31:0] random_coef();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3, 4, 5: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         6: begin
            case ($urandom_range(0, 5))
               0:       v = 32'h0000_0000;
               1:       v = 32'h0000_0001;
               2:       v = 32'hffff_ffff;
               3:       v = 32'h7fff_ffff;
               4:       v = 32'h8000_0000;
               default: v = 32'h7fff_ff00;
            endcase
         end
         default: v = 32'h0000_0000;
      endcase
      return v;
   endfunction

   task automatic send_pair(input logic [31:0] coef_a, input logic [31:0] coef_b,
                            input logic last);
      int gap;
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= coef_a;
      req_coef_b <= coef_b;
      req_last_pair <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_gain(input logic [8:0] pattern);
      drain();
      csr_write_enable <= 1'b1;
      csr_gain_index <= pattern;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int         length;
      logic       long_frames;
      logic [8:0] gain_pattern;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_pair(32'h0000_0001, 32'hffff_ffff, 1'b0);
      send_pair(32'd160, -32'd159, 1'b0);
      send_pair(-32'd160, 32'd159, 1'b0);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h7fff_ff00, 32'h8000_0100, 1'b1);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
      write_gain(9'h100);
      send_pair(32'h0000_0001, 32'hffff_ffff, 1'b0);
      send_pair(32'h0000_0000, 32'h0000_0100, 1'b0);
      send_pair(32'hffff_ff00, 32'h0000_0000, 1'b1);
      write_gain(9'd255);
      send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h1234_5678, 32'hedcb_a988, 1'b1);
      write_gain(9'h101);
      send_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      send_pair(32'h0000_0002, 32'hffff_fffe, 1'b1);
      write_gain(9'd28);
      send_pair(32'd2560, -32'd2560, 1'b1);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       gain_pattern = 9'd0;
            1:       gain_pattern = 9'd1;
            2:       gain_pattern = 9'h1ff;
            3:       gain_pattern = 9'd28;
            4:       gain_pattern = 9'h1e4;
            6:       gain_pattern = 9'd255;
            7:       gain_pattern = 9'h101;
            default: gain_pattern = $urandom_range(0, 511);
         endcase
         long_frames = (phase == 3) || (phase == 7);
         length = long_frames ? 300 : 180;
         write_gain(gain_pattern);
         for (int n = 0; n < length; n++) begin
            send_pair(random_coef(), random_coef(),
                      long_frames ? 1'b0 : ($urandom_range(0, 19) == 0));
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- spectral_gain_quantizer.f -----
rtl/sgq_pkg.sv
rtl/sgq_gain.sv
rtl/sgq_lane.sv
rtl/sgq_merge.sv
rtl/spectral_gain_quantizer.sv
rtl/sgq_checker.sv
tb/sgq_checker.sv
tb/tb_spectral_gain_quantizer.sv
